@@ hw/rtl/atcs_pkg.sv @@
// shared types and constants for the adaptive touch coordinate smoother
// no dependencies; used by every module under hw/rtl
`default_nettype none

package atcs_pkg;

    // sample and axis sizing
    localparam int SAMPLE_BITS       = 12;
    localparam int FILTERED_CHANNELS = 2;
    localparam int CHANNEL_BITS      = 2;
    localparam int AXIS_IDX_BITS     = (FILTERED_CHANNELS > 1) ? $clog2(FILTERED_CHANNELS) : 1;
    localparam int THRESH_BITS       = 12;

    // configuration port sizing
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 2;

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_REJECT = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_JUMP   = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FAST   = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_MEDIUM = 2'd3;

    // register reset values
    localparam logic [THRESH_BITS-1:0] REJECT_RESET = 12'd1000;
    localparam logic [THRESH_BITS-1:0] JUMP_RESET   = 12'd800;
    localparam logic [THRESH_BITS-1:0] FAST_RESET   = 12'd200;
    localparam logic [THRESH_BITS-1:0] MEDIUM_RESET = 12'd100;

    // request actions
    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [CHANNEL_BITS-1:0] channel;
        logic [SAMPLE_BITS-1:0]  sample;
    } req_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] filtered;
        logic                   ignored;
    } rsp_item_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] reject_threshold;
        logic [THRESH_BITS-1:0] jump_threshold;
        logic [THRESH_BITS-1:0] fast_threshold;
        logic [THRESH_BITS-1:0] medium_threshold;
    } thresh_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/atcs_regs.sv @@
// threshold registers behind the apb-style configuration port
// depends on atcs_pkg
`default_nettype none

module atcs_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [atcs_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [atcs_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [atcs_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                     pready,
    output atcs_pkg::thresh_cfg_t                    cfg
);

    atcs_pkg::thresh_cfg_t               cfg_reg;
    logic [atcs_pkg::REG_IDX_BITS-1:0]   reg_idx;
    logic [atcs_pkg::THRESH_BITS-1:0]    wr_val;
    logic [atcs_pkg::THRESH_BITS-1:0]    rd_val;
    logic                                wr_en;

    assign reg_idx = paddr[atcs_pkg::REG_IDX_BITS+1:2];
    assign wr_val  = pwdata[atcs_pkg::THRESH_BITS-1:0];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reject_threshold <= atcs_pkg::REJECT_RESET;
            cfg_reg.jump_threshold   <= atcs_pkg::JUMP_RESET;
            cfg_reg.fast_threshold   <= atcs_pkg::FAST_RESET;
            cfg_reg.medium_threshold <= atcs_pkg::MEDIUM_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                atcs_pkg::REG_REJECT: cfg_reg.reject_threshold <= wr_val;
                atcs_pkg::REG_JUMP:   cfg_reg.jump_threshold   <= wr_val;
                atcs_pkg::REG_FAST:   cfg_reg.fast_threshold   <= wr_val;
                atcs_pkg::REG_MEDIUM: cfg_reg.medium_threshold <= wr_val;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            atcs_pkg::REG_REJECT: rd_val = cfg_reg.reject_threshold;
            atcs_pkg::REG_JUMP:   rd_val = cfg_reg.jump_threshold;
            atcs_pkg::REG_FAST:   rd_val = cfg_reg.fast_threshold;
            atcs_pkg::REG_MEDIUM: rd_val = cfg_reg.medium_threshold;
            default:              rd_val = '0;
        endcase
    end

    assign prdata = {{(atcs_pkg::APB_DATA_BITS-atcs_pkg::THRESH_BITS){1'b0}}, rd_val};

endmodule

`default_nettype wire

@@ hw/rtl/atcs_core.sv @@
// per-axis accumulators, primed flags and the adaptive averaging datapath
// depends on atcs_pkg
`default_nettype none

module atcs_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  atcs_pkg::thresh_cfg_t       cfg,
    input  atcs_pkg::req_item_t         item,
    input  wire logic                   fire,
    output logic                        has_result,
    output atcs_pkg::rsp_item_t         result
);

    localparam int SB = atcs_pkg::SAMPLE_BITS;
    localparam int FC = atcs_pkg::FILTERED_CHANNELS;
    localparam int AB = atcs_pkg::AXIS_IDX_BITS;

    logic [SB-1:0] avg_reg    [FC];
    logic [SB-1:0] avg_next   [FC];
    logic [FC-1:0] primed_reg;
    logic [FC-1:0] primed_next;

    logic          is_flush;
    logic          is_filtered;
    logic [AB-1:0] axis;
    logic [SB-1:0] acc;
    logic          primed;
    logic [SB-1:0] first_dist;
    logic          reject;
    logic [SB-1:0] base;
    logic [SB-1:0] delta;
    logic [SB:0]   half_sum;
    logic [SB+1:0] quarter_sum;
    logic [SB-1:0] smoothed;

    assign is_flush    = (item.action == atcs_pkg::ACT_FLUSH);
    assign is_filtered = ({{(32-atcs_pkg::CHANNEL_BITS){1'b0}}, item.channel} < 32'(FC));
    assign axis        = AB'(item.channel);
    assign acc         = avg_reg[axis];
    assign primed      = primed_reg[axis];

    // first-sample distance check
    assign first_dist = (acc > item.sample) ? (acc - item.sample) : (item.sample - acc);
    assign reject     = !primed && (first_dist > cfg.reject_threshold);

    // pick averaging length from distance to the base value
    assign base        = primed ? acc : item.sample;
    assign delta       = (base > item.sample) ? (base - item.sample) : (item.sample - base);
    assign half_sum    = {1'b0, base} + {1'b0, item.sample};
    assign quarter_sum = {base, 1'b0} + {2'b00, base} + {2'b00, item.sample};

    always_comb
    begin
        if ((delta > cfg.jump_threshold) || (delta > cfg.fast_threshold))
        begin
            // fast move or jump: take the new sample
            smoothed = item.sample;
        end
        else if (delta > cfg.medium_threshold)
        begin
            smoothed = half_sum[SB:1];
        end
        else
        begin
            smoothed = quarter_sum[SB+1:2];
        end
    end

    // result and next state
    always_comb
    begin
        avg_next    = avg_reg;
        primed_next = primed_reg;
        has_result  = 1'b0;
        result.filtered = item.sample;
        result.ignored  = 1'b0;
        if (fire)
        begin
            if (is_flush)
            begin
                primed_next = '0;
            end
            else if (!is_filtered)
            begin
                has_result = 1'b1;
            end
            else if (reject)
            begin
                has_result      = 1'b1;
                result.ignored  = 1'b1;
                avg_next[axis]  = item.sample;
            end
            else
            begin
                has_result        = 1'b1;
                result.filtered   = smoothed;
                avg_next[axis]    = smoothed;
                primed_next[axis] = 1'b1;
            end
        end
    end

    // axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FC; i++)
            begin
                avg_reg[i] <= '0;
            end
            primed_reg <= '0;
        end
        else
        begin
            avg_reg    <= avg_next;
            primed_reg <= primed_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/adaptive_touch_coordinate_smoother.sv @@
// A request accepted into the input register moves through the smoothing core
// into the output register, where any response it yields waits until taken.
// Throughput: one request per cycle unless rsp_stall holds a full output
// register; the input register frees whenever the output register is empty or
// being taken, and a flush never waits on it. Reset: thresholds return to
// 1000/800/200/100, accumulators and primed flags clear, both pipeline registers empty.
// top level: input register, smoothing core, output register, threshold regs
// depends on atcs_pkg, atcs_regs, atcs_core
`default_nettype none

module adaptive_touch_coordinate_smoother (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  atcs_pkg::req_item_t                      req_data,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output atcs_pkg::rsp_item_t                      rsp_data,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [atcs_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [atcs_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [atcs_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                     pready
);

    atcs_pkg::thresh_cfg_t cfg;
    atcs_pkg::req_item_t   in_data_reg;
    logic                  in_valid_reg;
    atcs_pkg::rsp_item_t   out_data_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  take;
    logic                  has_result;
    atcs_pkg::rsp_item_t   result;

    atcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // held request moves on when the output slot is free or a flush
    assign advance   = in_valid_reg &&
                       ((in_data_reg.action == atcs_pkg::ACT_FLUSH) ||
                        !out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign take      = req_valid && !req_stall;

    atcs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (in_data_reg),
        .fire       (advance),
        .has_result (has_result),
        .result     (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= req_data;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (has_result)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

`default_nettype wire
